@@ hw/rtl/der_pkg.sv @@
// shared types and command codes for the disk elevator request sequencer
// no dependencies
`timescale 1ns / 1ps

package der_pkg;

    // one queued disk request
    typedef struct packed {
        logic [2:0]  unit;
        logic [9:0]  cyl;
        logic [4:0]  trk;
        logic [5:0]  sec;
        logic [15:0] bcount;
        logic        rd;
        logic [17:0] addr;
        logic [7:0]  tag;
    } t_req;

    // per-cell command codes
    typedef logic [2:0] t_cell_cmd;
    localparam t_cell_cmd CMD_HOLD      = 3'd0;
    localparam t_cell_cmd CMD_LOAD_NEW  = 3'd1;
    localparam t_cell_cmd CMD_FROM_PREV = 3'd2;
    localparam t_cell_cmd CMD_FROM_NEXT = 3'd3;
    localparam t_cell_cmd CMD_ADVANCE   = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_REJECT   = 3'd0;
    localparam logic [2:0] KIND_ISSUE    = 3'd1;
    localparam logic [2:0] KIND_RECAL    = 3'd2;
    localparam logic [2:0] KIND_DONE_OK  = 3'd3;
    localparam logic [2:0] KIND_DONE_ERR = 3'd4;

    // opcodes
    localparam logic [1:0] OP_SUBMIT  = 2'd0;
    localparam logic [1:0] OP_DONE_OK = 2'd1;
    localparam logic [1:0] OP_DONE_ER = 2'd2;

    localparam int NUM_GEO = 8;

endpackage

@@ hw/rtl/der_cell.sv @@
// one queue cell of the elevator chain: holds a request, shifts with neighbors
// depends on der_pkg
`timescale 1ns / 1ps

module der_cell #(
    parameter int SECTORS_PER_TRACK   = 32,
    parameter int TRACKS_PER_CYLINDER = 5
) (
    input  logic               i_clk,
    input  der_pkg::t_cell_cmd i_cmd,
    input  der_pkg::t_req      i_new,
    input  der_pkg::t_req      i_prev,
    input  der_pkg::t_req      i_next,
    input  logic [9:0]         i_key_cyl,
    output der_pkg::t_req      o_entry,
    output logic               o_match
);
    import der_pkg::*;

    t_req        r_entry;
    t_req        n_entry;
    logic [16:0] w_chunk;
    logic [5:0]  w_trk_inc;

    assign w_chunk   = (17'(SECTORS_PER_TRACK) - 17'(r_entry.sec)) << 9;
    assign w_trk_inc = {1'b0, r_entry.trk} + 6'd1;

    // new key fits between this cell and its successor
    assign o_match = ((r_entry.cyl <= i_key_cyl) && (i_key_cyl < i_next.cyl)) ||
                     ((r_entry.cyl >= i_key_cyl) && (i_key_cyl > i_next.cyl));

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd)
            CMD_LOAD_NEW:  n_entry = i_new;
            CMD_FROM_PREV: n_entry = i_prev;
            CMD_FROM_NEXT: n_entry = i_next;
            CMD_ADVANCE: begin
                n_entry.bcount = r_entry.bcount - w_chunk[15:0];
                n_entry.addr   = r_entry.addr + 18'(w_chunk);
                n_entry.sec    = '0;
                if (w_trk_inc >= 6'(TRACKS_PER_CYLINDER)) begin
                    n_entry.trk = '0;
                    n_entry.cyl = r_entry.cyl + 10'd1;
                end else begin
                    n_entry.trk = w_trk_inc[4:0];
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

@@ hw/rtl/disk_elevator_request_sequencer.sv @@
// disk request sequencer: block to cylinder/track/sector translation,
// elevator queue built as a chain of der_cell, one command per track
// depends on der_pkg and der_cell
//
//  channel | signals                               | direction
//  --------+---------------------------------------+-----------
//  in      | i_in_valid / o_in_ready + fields       | request in
//  out     | o_out_valid / i_out_ready + fields     | result out
//  cfg     | i_cfg_valid / o_cfg_ready, index, data | register write
//
// an accepted submit passes through translation states XL1, XL2 and XL3, the
// ordering scan walking up to QUEUE_DEPTH - 2 queue cells and the insert, then
// an issue when idle; a rejected submit goes from XL1 to REJ; translation uses
// 2 reciprocal multiplies; a completion goes through EVAL to RECAL, ISSUE or COMP
// results leave through one output register; a stalled output holds the
// sequencer, and the next request is taken while the last result waits
// reset clears control state and loads the default geometry; queue cells
// carry no reset, the fill count tracks what is valid
`timescale 1ns / 1ps

module disk_elevator_request_sequencer #(
    parameter int QUEUE_DEPTH         = 16,
    parameter int NUM_UNITS           = 3,
    parameter int SECTORS_PER_TRACK   = 32,
    parameter int TRACKS_PER_CYLINDER = 5,
    parameter int MAX_RETRIES         = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_unit,
    input  logic [2:0]  i_partition,
    input  logic [19:0] i_block,
    input  logic [15:0] i_byte_count,
    input  logic        i_is_read,
    input  logic [17:0] i_bus_address,
    input  logic [7:0]  i_tag,
    input  logic        i_recal_needed,
    input  logic [15:0] i_residual_words,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_out_unit,
    output logic [9:0]  o_cylinder,
    output logic [2:0]  o_track,
    output logic [4:0]  o_sector,
    output logic [14:0] o_word_count,
    output logic        o_out_is_read,
    output logic [17:0] o_out_bus_address,
    output logic [7:0]  o_out_tag,
    output logic [16:0] o_residual_bytes,
    output logic        o_last,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [29:0] i_cfg_data
);
    import der_pkg::*;

    localparam int LW  = $clog2(QUEUE_DEPTH + 1);
    localparam int IW  = $clog2(QUEUE_DEPTH);
    localparam int SW  = $clog2(SECTORS_PER_TRACK);
    localparam int TW  = $clog2(TRACKS_PER_CYLINDER);

    // rounded-up reciprocals, exact for any 20-bit dividend
    localparam logic [21:0] S_RECIP =
        22'(((1 << (20 + SW)) + SECTORS_PER_TRACK - 1) / SECTORS_PER_TRACK);
    localparam logic [21:0] T_RECIP =
        22'(((1 << (20 + TW)) + TRACKS_PER_CYLINDER - 1) / TRACKS_PER_CYLINDER);

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_XL1    = 4'd1;
    localparam logic [3:0] ST_XL2    = 4'd2;
    localparam logic [3:0] ST_SCAN   = 4'd3;
    localparam logic [3:0] ST_INSERT = 4'd4;
    localparam logic [3:0] ST_REJ    = 4'd5;
    localparam logic [3:0] ST_ISSUE  = 4'd6;
    localparam logic [3:0] ST_EVAL   = 4'd7;
    localparam logic [3:0] ST_RECAL  = 4'd8;
    localparam logic [3:0] ST_COMP   = 4'd9;
    localparam logic [3:0] ST_XL3    = 4'd10;

    // control state
    logic [3:0]    r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic          r_busy, n_busy;
    logic [2:0]    r_retry, n_retry;
    logic          r_split, n_split;   // request is being split over tracks
    logic [IW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_pos, n_pos;
    logic [2:0]    r_ckind, n_ckind;
    logic [29:0]   r_geo [NUM_GEO];

    // latched request
    logic [1:0]  r_op;
    logic [2:0]  r_part;
    logic [19:0] r_blk;
    logic        r_recal;
    logic [15:0] r_resid;
    t_req        r_new;
    logic [19:0] r_tracks;
    logic [19:0] r_cylq;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [2:0]  r_unit_o;
    logic [9:0]  r_cyl_o;
    logic [2:0]  r_trk_o;
    logic [4:0]  r_sec_o;
    logic [14:0] r_wc_o;
    logic        r_rd_o;
    logic [17:0] r_addr_o;
    logic [7:0]  r_tag_o;
    logic [16:0] r_res_o;
    logic        r_last_o;

    logic           w_in_acc;
    logic           w_can_put;
    logic           w_put;
    logic [2:0]     w_kind;
    t_req           w_src;
    logic [9:0]     w_cyl;
    logic [2:0]     w_trk;
    logic [4:0]     w_sec;
    logic [14:0]    w_wc;
    logic           w_rd;
    logic [17:0]    w_addr;
    logic [16:0]    w_res;
    logic           w_last;

    t_req           w_ent   [QUEUE_DEPTH];
    t_cell_cmd      w_cmd   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_match;
    logic           w_shift_in;
    logic           w_pop;
    logic           w_adv;

    t_req           w_head;
    logic [16:0]    w_chunk;
    logic           w_cross;
    logic [29:0]    w_geo_sel;
    logic           w_reject;
    logic [3:0]     w_retry_inc;
    logic           w_retry_ok;

    logic [41:0]    w_blk_prod;
    logic [41:0]    w_trk_prod;
    logic [19:0]    w_sec_rem;
    logic [19:0]    w_trk_rem;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_can_put   = !r_out_valid || i_out_ready;

    // queue chain
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_req w_prev;
        t_req w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_ent[0];
        end else begin : g_mid
            assign w_prev = w_ent[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next = w_ent[g];
        end else begin : g_body
            assign w_next = w_ent[g+1];
        end

        always_comb begin
            w_cmd[g] = CMD_HOLD;
            if (w_shift_in) begin
                if (LW'(g) == r_pos) begin
                    w_cmd[g] = CMD_LOAD_NEW;
                end else if (LW'(g) > r_pos) begin
                    w_cmd[g] = CMD_FROM_PREV;
                end
            end else if (w_pop) begin
                w_cmd[g] = CMD_FROM_NEXT;
            end else if (w_adv && g == 0) begin
                w_cmd[g] = CMD_ADVANCE;
            end
        end

        der_cell #(
            .SECTORS_PER_TRACK   (SECTORS_PER_TRACK),
            .TRACKS_PER_CYLINDER (TRACKS_PER_CYLINDER)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd[g]),
            .i_new     (r_new),
            .i_prev    (w_prev),
            .i_next    (w_next),
            .i_key_cyl (r_new.cyl),
            .o_entry   (w_ent[g]),
            .o_match   (w_match[g])
        );
    end

    // head request view
    assign w_head  = w_ent[0];
    assign w_chunk = (17'(SECTORS_PER_TRACK) - 17'(w_head.sec)) << 9;
    assign w_cross = ({2'b00, w_head.sec} + {1'b0, w_head.bcount[15:9]}) >=
                     8'(SECTORS_PER_TRACK);

    assign w_geo_sel   = r_geo[r_part];
    assign w_reject    = ({1'b0, r_new.unit} >= 4'(NUM_UNITS)) ||
                         (r_blk >= w_geo_sel[19:0]) ||
                         (r_len >= LW'(QUEUE_DEPTH));
    assign w_retry_inc = {1'b0, r_retry} + 4'd1;
    assign w_retry_ok  = (w_retry_inc <= 4'(MAX_RETRIES));

    // translation: block / sectors, then tracks / heads, by reciprocal multiply
    assign w_blk_prod = {22'd0, r_blk} * {20'd0, S_RECIP};
    assign w_sec_rem  = r_blk - r_tracks * 20'(SECTORS_PER_TRACK);
    assign w_trk_prod = {22'd0, r_tracks} * {20'd0, T_RECIP};
    assign w_trk_rem  = r_tracks - r_cylq * 20'(TRACKS_PER_CYLINDER);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_busy     = r_busy;
        n_retry    = r_retry;
        n_split    = r_split;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_ckind    = r_ckind;
        w_shift_in = 1'b0;
        w_pop      = 1'b0;
        w_adv      = 1'b0;
        w_put      = 1'b0;
        w_kind     = KIND_REJECT;
        w_src      = w_head;
        w_cyl      = '0;
        w_trk      = '0;
        w_sec      = '0;
        w_wc       = '0;
        w_rd       = 1'b0;
        w_addr     = '0;
        w_res      = '0;
        w_last     = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_opcode == OP_SUBMIT) begin
                        n_state = ST_XL1;
                    end else if (i_opcode == OP_DONE_OK || i_opcode == OP_DONE_ER) begin
                        n_busy = 1'b0;
                        if (r_busy && r_len != '0) begin
                            n_state = ST_EVAL;
                        end
                    end
                end
            end
            ST_XL1: begin
                n_state = w_reject ? ST_REJ : ST_XL2;
            end
            ST_XL2: begin
                n_idx   = '0;
                n_state = ST_XL3;
            end
            ST_XL3: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // walk the chain until the new cylinder fits between two cells
                if (r_len == '0) begin
                    n_pos   = '0;
                    n_state = ST_INSERT;
                end else if ((LW'(r_idx) + LW'(1) < r_len) && !w_match[r_idx]) begin
                    n_idx = r_idx + IW'(1);
                end else begin
                    n_pos   = LW'(r_idx) + LW'(1);
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                w_shift_in = 1'b1;
                n_len      = r_len + LW'(1);
                n_state    = r_busy ? ST_IDLE : ST_ISSUE;
            end
            ST_REJ: begin
                if (w_can_put) begin
                    w_put   = 1'b1;
                    w_kind  = KIND_REJECT;
                    w_src   = r_new;
                    n_state = ST_IDLE;
                end
            end
            ST_ISSUE: begin
                if (w_can_put) begin
                    w_put  = 1'b1;
                    w_kind = KIND_ISSUE;
                    w_cyl  = w_head.cyl;
                    w_trk  = w_head.trk[2:0];
                    w_sec  = w_head.sec[4:0];
                    w_wc   = w_cross ? 15'(w_chunk >> 1) : w_head.bcount[15:1];
                    w_rd   = w_head.rd;
                    w_addr = w_head.addr;
                    if (w_cross) begin
                        n_split = 1'b1;
                    end
                    n_busy  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_EVAL: begin
                if (r_op == OP_DONE_ER) begin
                    if (r_recal) begin
                        n_state = ST_RECAL;
                    end else if (w_retry_ok) begin
                        n_retry = w_retry_inc[2:0];
                        n_state = ST_ISSUE;
                    end else begin
                        n_ckind = KIND_DONE_ERR;
                        n_state = ST_COMP;
                    end
                end else if (r_split && ({1'b0, w_head.bcount} > w_chunk)) begin
                    // next track of a split transfer
                    w_adv   = 1'b1;
                    n_state = ST_ISSUE;
                end else begin
                    n_ckind = KIND_DONE_OK;
                    n_state = ST_COMP;
                end
            end
            ST_RECAL: begin
                if (w_can_put) begin
                    w_put  = 1'b1;
                    w_kind = KIND_RECAL;
                    w_last = 1'b0;
                    if (w_retry_ok) begin
                        n_retry = w_retry_inc[2:0];
                        n_state = ST_ISSUE;
                    end else begin
                        n_ckind = KIND_DONE_ERR;
                        n_state = ST_COMP;
                    end
                end
            end
            ST_COMP: begin
                if (w_can_put) begin
                    w_put   = 1'b1;
                    w_kind  = r_ckind;
                    w_rd    = w_head.rd;
                    w_res   = {r_resid, 1'b0};
                    w_last  = (r_len == LW'(1));
                    w_pop   = 1'b1;
                    n_len   = r_len - LW'(1);
                    n_retry = '0;
                    n_split = 1'b0;
                    n_state = (r_len > LW'(1)) ? ST_ISSUE : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_busy      <= 1'b0;
            r_retry     <= '0;
            r_split     <= 1'b0;
            r_idx       <= '0;
            r_pos       <= '0;
            r_ckind     <= KIND_DONE_OK;
            r_out_valid <= 1'b0;
            r_geo[0]    <= 30'd15884;
            r_geo[1]    <= 30'd104891040;
            r_geo[2]    <= 30'd268443936;
            r_geo[3]    <= '0;
            r_geo[4]    <= '0;
            r_geo[5]    <= '0;
            r_geo[6]    <= '0;
            r_geo[7]    <= 30'd324092224;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_busy  <= n_busy;
            r_retry <= n_retry;
            r_split <= n_split;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            r_ckind <= n_ckind;
            if (w_put) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < 4'(NUM_GEO)) begin
                r_geo[i_cfg_index[2:0]] <= i_cfg_data;
            end
        end
    end

    // request latch and translation
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op         <= i_opcode;
            r_part       <= i_partition;
            r_blk        <= i_block;
            r_recal      <= i_recal_needed;
            r_resid      <= i_residual_words;
            r_new.unit   <= i_unit;
            r_new.bcount <= i_byte_count;
            r_new.rd     <= i_is_read;
            r_new.addr   <= i_bus_address;
            r_new.tag    <= i_tag;
        end
        if (r_state == ST_XL1) begin
            r_tracks <= 20'(w_blk_prod >> (20 + SW));
        end
        if (r_state == ST_XL2) begin
            r_new.sec <= w_sec_rem[5:0];
            r_cylq    <= 20'(w_trk_prod >> (20 + TW));
        end
        if (r_state == ST_XL3) begin
            r_new.trk <= w_trk_rem[4:0];
            r_new.cyl <= w_geo_sel[29:20] + r_cylq[9:0];
        end
        if (w_put) begin
            r_kind   <= w_kind;
            r_unit_o <= w_src.unit;
            r_tag_o  <= w_src.tag;
            r_cyl_o  <= w_cyl;
            r_trk_o  <= w_trk;
            r_sec_o  <= w_sec;
            r_wc_o   <= w_wc;
            r_rd_o   <= w_rd;
            r_addr_o <= w_addr;
            r_res_o  <= w_res;
            r_last_o <= w_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_out_unit        = r_unit_o;
    assign o_cylinder        = r_cyl_o;
    assign o_track           = r_trk_o;
    assign o_sector          = r_sec_o;
    assign o_word_count      = r_wc_o;
    assign o_out_is_read     = r_rd_o;
    assign o_out_bus_address = r_addr_o;
    assign o_out_tag         = r_tag_o;
    assign o_residual_bytes  = r_res_o;
    assign o_last            = r_last_o;

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(QUEUE_DEPTH))
        else $error("queue fill count past depth");

    a_busy_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_len != '0))
        else $error("busy with an empty queue");

    a_retry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_retry <= 3'(MAX_RETRIES))
        else $error("retry count past limit");

    a_comp_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP && w_can_put) |=> (r_retry == '0 && !r_split))
        else $error("completion left retry or split state");
`endif

endmodule
